[rtl/cdq_pkg.sv]
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int STAGES   = 9;
    localparam int COMP_W   = 32;
    localparam int ABS_W    = 31;
    localparam int IN_BITS  = 8 * COMP_W;
    localparam int OUT_BITS = ((4 * ABS_W + 7) / 8) * 8;

    localparam logic [30:0] HALF_SQRT2 = 31'd1518500250;

    // negated terms of each product component, bit t for the term taking p[t]
    localparam logic [3:0] TERM_NEG [4] = '{4'b0000, 4'b1001, 4'b0011, 4'b0101};

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic [ABS_W-1:0]         t_mag;
    typedef logic [3:0][ABS_W-1:0]    t_mag4;

    function automatic t_comp sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483647) begin
            return 32'sh80000001;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic t_mag abs31(input t_comp v);
        t_comp neg;
        neg = -v;
        return v[31] ? neg[30:0] : v[30:0];
    endfunction

endpackage

[rtl/cubic_disorientation_quaternion_top.sv]
`timescale 1ns / 1ps

// Cubic disorientation quaternion, streaming.
// Input channel (i_s_axis_*): one transaction carries two orientations q and p
// as eight signed Q2.30 words. Output channel (o_m_axis_*): one transaction
// carries the four absolute components of the chosen cubic-symmetry candidate
// of conj(q)*p, unsigned Q1.30, largest first.
// Throughput: one transaction per cycle while the output is not stalled, set by
// a nine-stage pipeline in which every stage has its own register and valid
// bit: products, term sum, rounding, candidate sums, scaling multiply,
// saturation and magnitude, per-candidate maximum, candidate select, sorting
// network. A transaction accepted at the input passes the nine register
// stages in order before it is offered at the output.
// Reset (synchronous, active low) clears all valid bits; data in flight is
// dropped. When the receiver stalls, the output register holds its
// transaction and upstream stages keep filling until the first full stage
// that cannot advance; o_s_axis_tready falls only when the whole pipe is full.
module cubic_disorientation_quaternion_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z
    input  logic [cdq_pkg::IN_BITS-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // out_largest, out_second, out_third, out_smallest, zero fill
    output logic [cdq_pkg::OUT_BITS-1:0]  o_m_axis_tdata
);
    import cdq_pkg::*;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;

    t_comp q [4];
    t_comp p [4];

    logic signed [63:0] r_prod [4][4];
    logic signed [63:0] n_prod [4][4];
    logic signed [63:0] r_sum [4];
    logic signed [63:0] n_sum [4];
    t_comp              r_comp3 [4];
    t_comp              n_comp3 [4];
    logic signed [32:0] r_pair [12];
    logic signed [32:0] n_pair [12];
    logic signed [33:0] r_quad [8];
    logic signed [33:0] n_quad [8];
    t_comp              r_comp4 [4];
    logic signed [63:0] r_scl [12];
    logic signed [63:0] n_scl [12];
    t_comp              r_half [8];
    t_comp              n_half [8];
    t_comp              r_comp5 [4];
    t_mag4              r_abs6 [6];
    t_mag4              n_abs6 [6];
    t_mag4              r_abs7 [6];
    t_mag               r_cmax [6];
    t_mag               n_cmax [6];
    t_mag4              r_sel_v;
    t_mag4              n_sel_v;
    t_mag               r_best;
    t_mag               n_best;
    t_mag4              r_sort;
    t_mag4              n_sort;

    // stage handshake
    always_comb begin
        w_en[STAGES-1] = !r_vld[STAGES-1] || i_m_axis_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = {r_vld[STAGES-2:0], i_s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // stage 1: partial products q[k^t] * p[t]
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q[i] = i_s_axis_tdata[COMP_W*i +: COMP_W];
            p[i] = i_s_axis_tdata[COMP_W*(i+4) +: COMP_W];
        end
        for (int k = 0; k < 4; k++) begin
            for (int t = 0; t < 4; t++) begin
                n_prod[k][t] = q[k ^ t] * p[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_prod <= n_prod;
        end
    end

    // stage 2: signed terms floored to 2^-58, summed
    always_comb begin : s2_sum
        logic signed [63:0] term;
        term = '0;
        for (int k = 0; k < 4; k++) begin
            n_sum[k] = '0;
            for (int t = 0; t < 4; t++) begin
                term     = TERM_NEG[k][t] ? -r_prod[k][t] : r_prod[k][t];
                n_sum[k] = n_sum[k] + (term >>> 2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_sum <= n_sum;
        end
    end

    // stage 3: round to Q2.30 and saturate
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_comp3[k] = sat32((r_sum[k] + 64'sd134217728) >>> 28);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_comp3 <= n_comp3;
        end
    end

    // stage 4: candidate sums
    always_comb begin : s4_sums
        logic signed [32:0] a2, b2, c2, d2;
        logic signed [33:0] a4, b4, c4, d4;
        a2 = {r_comp3[0][31], r_comp3[0]};
        b2 = {r_comp3[1][31], r_comp3[1]};
        c2 = {r_comp3[2][31], r_comp3[2]};
        d2 = {r_comp3[3][31], r_comp3[3]};
        a4 = {a2[32], a2};
        b4 = {b2[32], b2};
        c4 = {c2[32], c2};
        d4 = {d2[32], d2};
        n_pair[0]  = a2 + b2;
        n_pair[1]  = a2 - b2;
        n_pair[2]  = c2 + d2;
        n_pair[3]  = c2 - d2;
        n_pair[4]  = a2 + c2;
        n_pair[5]  = a2 - c2;
        n_pair[6]  = b2 + d2;
        n_pair[7]  = b2 - d2;
        n_pair[8]  = a2 + d2;
        n_pair[9]  = a2 - d2;
        n_pair[10] = b2 + c2;
        n_pair[11] = b2 - c2;
        n_quad[0]  = a4 + b4 + c4 + d4;
        n_quad[1]  = a4 + b4 - c4 - d4;
        n_quad[2]  = a4 - b4 + c4 - d4;
        n_quad[3]  = a4 - b4 - c4 + d4;
        n_quad[4]  = a4 + b4 + c4 - d4;
        n_quad[5]  = a4 + b4 - c4 + d4;
        n_quad[6]  = a4 - b4 + c4 + d4;
        n_quad[7]  = a4 - b4 - c4 - d4;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_pair  <= n_pair;
            r_quad  <= n_quad;
            r_comp4 <= r_comp3;
        end
    end

    // stage 5: scale pair sums, halve quad sums
    always_comb begin : s5_scale
        logic signed [63:0] hv;
        hv = '0;
        for (int i = 0; i < 12; i++) begin
            n_scl[i] = r_pair[i] * $signed({1'b0, HALF_SQRT2});
        end
        for (int i = 0; i < 8; i++) begin
            hv        = 64'(r_quad[i]);
            n_half[i] = sat32((hv + 64'sd1) >>> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_scl   <= n_scl;
            r_half  <= n_half;
            r_comp5 <= r_comp4;
        end
    end

    // stage 6: round scaled values, take magnitudes of all candidates
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
                n_abs6[c][j] = abs31(sat32((r_scl[4*c+j] + 64'sd1073741824) >>> 31));
            end
        end
        for (int c = 0; c < 2; c++) begin
            for (int j = 0; j < 4; j++) begin
                n_abs6[c+3][j] = abs31(r_half[4*c+j]);
            end
        end
        for (int j = 0; j < 4; j++) begin
            n_abs6[5][j] = abs31(r_comp5[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_abs6 <= n_abs6;
        end
    end

    // stage 7: largest magnitude of each candidate
    always_comb begin : s7_max
        t_mag m01, m23;
        m01 = '0;
        m23 = '0;
        for (int c = 0; c < 6; c++) begin
            m01       = (r_abs6[c][1] > r_abs6[c][0]) ? r_abs6[c][1] : r_abs6[c][0];
            m23       = (r_abs6[c][3] > r_abs6[c][2]) ? r_abs6[c][3] : r_abs6[c][2];
            n_cmax[c] = (m23 > m01) ? m23 : m01;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_cmax <= n_cmax;
            r_abs7 <= r_abs6;
        end
    end

    // stage 8: earliest candidate holding the overall maximum
    always_comb begin : s8_select
        logic [2:0] i01, i23, i45, i03, isel;
        t_mag       v01, v23, v45, v03;
        i01  = (r_cmax[1] > r_cmax[0]) ? 3'd1 : 3'd0;
        v01  = (r_cmax[1] > r_cmax[0]) ? r_cmax[1] : r_cmax[0];
        i23  = (r_cmax[3] > r_cmax[2]) ? 3'd3 : 3'd2;
        v23  = (r_cmax[3] > r_cmax[2]) ? r_cmax[3] : r_cmax[2];
        i45  = (r_cmax[5] > r_cmax[4]) ? 3'd5 : 3'd4;
        v45  = (r_cmax[5] > r_cmax[4]) ? r_cmax[5] : r_cmax[4];
        i03  = (v23 > v01) ? i23 : i01;
        v03  = (v23 > v01) ? v23 : v01;
        isel = (v45 > v03) ? i45 : i03;
        n_best  = (v45 > v03) ? v45 : v03;
        n_sel_v = r_abs7[0];
        for (int c = 1; c < 6; c++) begin
            if (isel == 3'(c)) begin
                n_sel_v = r_abs7[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_sel_v <= n_sel_v;
            r_best  <= n_best;
        end
    end

    // stage 9: descending sort network
    always_comb begin : s9_sort
        t_mag h0, h1, h2, h3, g0, g1, g2, g3;
        h0 = (r_sel_v[0] >= r_sel_v[1]) ? r_sel_v[0] : r_sel_v[1];
        h1 = (r_sel_v[0] >= r_sel_v[1]) ? r_sel_v[1] : r_sel_v[0];
        h2 = (r_sel_v[2] >= r_sel_v[3]) ? r_sel_v[2] : r_sel_v[3];
        h3 = (r_sel_v[2] >= r_sel_v[3]) ? r_sel_v[3] : r_sel_v[2];
        g0 = (h0 >= h2) ? h0 : h2;
        g2 = (h0 >= h2) ? h2 : h0;
        g1 = (h1 >= h3) ? h1 : h3;
        g3 = (h1 >= h3) ? h3 : h1;
        n_sort[0] = g0;
        n_sort[1] = (g1 >= g2) ? g1 : g2;
        n_sort[2] = (g1 >= g2) ? g2 : g1;
        n_sort[3] = g3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_sort <= n_sort;
        end
    end

    assign o_m_axis_tvalid = r_vld[STAGES-1];
    assign o_m_axis_tdata  = {{(OUT_BITS - 4*ABS_W){1'b0}},
                              r_sort[3], r_sort[2], r_sort[1], r_sort[0]};

`ifndef SYNTH
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output register empty");

    a_out_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_sort[0] >= r_sort[1]) && (r_sort[1] >= r_sort[2])
                            && (r_sort[2] >= r_sort[3]))
        else $error("result components not in descending order");

    a_sel_holds_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r_sel_v[0] == r_best) || (r_sel_v[1] == r_best)
                     || (r_sel_v[2] == r_best) || (r_sel_v[3] == r_best))
        else $error("selected candidate lacks the overall maximum");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

[bench/cubic_disorientation_quaternion_top_tb.sv]
`timescale 1ns / 1ps

module cubic_disorientation_quaternion_top_tb;

    import cdq_pkg::*;

    localparam int  RANDOM_PAIRS = 1200;
    localparam int  STALL_LIMIT  = 3000;
    localparam int  HOLD_AT      = 300;
    localparam int  HOLD_CYCLES  = 160;
    localparam longint Q_ONE     = 64'sd1073741824;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam longint ROOT_HALF = 64'sd1518500250;

    typedef struct packed {
        t_comp p_z, p_y, p_x, p_w;
        t_comp q_z, q_y, q_x, q_w;
    } quat_pair_t;

    typedef struct packed {
        logic [OUT_BITS-4*ABS_W-1:0] fill;
        t_mag smallest, third, second, largest;
    } mag_set_t;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // first_w, first_x, first_y, first_z, second_w, second_x, second_y, second_z
    logic [IN_BITS-1:0]   i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // out_largest, out_second, out_third, out_smallest, zero fill
    logic [OUT_BITS-1:0]  o_m_axis_tdata;

    quat_pair_t pair_q [$];
    mag_set_t   sorted_q [$];
    int         errors = 0;
    int         n_results = 0;

    cubic_disorientation_quaternion_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint clamp_q230(longint v);
        if (v > Q_MAX) begin
            return Q_MAX;
        end else if (v < -Q_MAX) begin
            return -Q_MAX;
        end
        return v;
    endfunction

    function automatic longint mul_term(bit neg, longint x, longint y);
        longint p;
        p = x * y;
        if (neg) begin
            p = -p;
        end
        return p >>> 2;
    endfunction

    function automatic longint round_q230(longint t0, longint t1, longint t2, longint t3);
        return clamp_q230((t0 + t1 + t2 + t3 + (64'sd1 <<< 27)) >>> 28);
    endfunction

    function automatic longint scale_root_half(longint s);
        return clamp_q230((s * ROOT_HALF + (64'sd1 <<< 30)) >>> 31);
    endfunction

    function automatic longint half_round(longint s);
        return clamp_q230((s + 1) >>> 1);
    endfunction

    function automatic longint mag_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic mag_set_t predict_disorientation(quat_pair_t qp);
        longint qw, qx, qy, qz, pw, px, py, pz;
        longint a, b, c, d, best, t;
        longint cand [6][4];
        longint v [4];
        int sel;
        mag_set_t r;
        qw = longint'($signed(qp.q_w));
        qx = longint'($signed(qp.q_x));
        qy = longint'($signed(qp.q_y));
        qz = longint'($signed(qp.q_z));
        pw = longint'($signed(qp.p_w));
        px = longint'($signed(qp.p_x));
        py = longint'($signed(qp.p_y));
        pz = longint'($signed(qp.p_z));
        a = round_q230(mul_term(0, qw, pw), mul_term(0, qx, px),
                       mul_term(0, qy, py), mul_term(0, qz, pz));
        b = round_q230(mul_term(1, qx, pw), mul_term(0, qw, px),
                       mul_term(0, qz, py), mul_term(1, qy, pz));
        c = round_q230(mul_term(1, qy, pw), mul_term(1, qz, px),
                       mul_term(0, qw, py), mul_term(0, qx, pz));
        d = round_q230(mul_term(1, qz, pw), mul_term(0, qy, px),
                       mul_term(1, qx, py), mul_term(0, qw, pz));
        cand[0] = '{scale_root_half(a + b), scale_root_half(a - b),
                    scale_root_half(c + d), scale_root_half(c - d)};
        cand[1] = '{scale_root_half(a + c), scale_root_half(a - c),
                    scale_root_half(b + d), scale_root_half(b - d)};
        cand[2] = '{scale_root_half(a + d), scale_root_half(a - d),
                    scale_root_half(b + c), scale_root_half(b - c)};
        cand[3] = '{half_round(a + b + c + d), half_round(a + b - c - d),
                    half_round(a - b + c - d), half_round(a - b - c + d)};
        cand[4] = '{half_round(a + b + c - d), half_round(a + b - c + d),
                    half_round(a - b + c + d), half_round(a - b - c - d)};
        cand[5] = '{a, b, c, d};
        best = 0;
        sel = 0;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 4; j++) begin
                if (mag_of(cand[i][j]) > best) begin
                    best = mag_of(cand[i][j]);
                    sel = i;
                end
            end
        end
        for (int j = 0; j < 4; j++) begin
            v[j] = mag_of(cand[sel][j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3 - i; j++) begin
                if (v[j] < v[j + 1]) begin
                    t = v[j];
                    v[j] = v[j + 1];
                    v[j + 1] = t;
                end
            end
        end
        r = '0;
        r.largest  = t_mag'(v[0]);
        r.second   = t_mag'(v[1]);
        r.third    = t_mag'(v[2]);
        r.smallest = t_mag'(v[3]);
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_comp rand_comp();
        int r;
        longint odd [6];
        odd = '{0, Q_MAX, Q_MIN, 1, -1, Q_ONE};
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return t_comp'(longint'($urandom_range(0, 32'h80000000)) - Q_ONE);
        end else if (r < 85) begin
            return t_comp'($urandom);
        end
        return t_comp'(odd[$urandom_range(0, 5)]);
    endfunction

    task automatic add_pair(longint qw, longint qx, longint qy, longint qz,
                            longint pw, longint px, longint py, longint pz);
        quat_pair_t qp;
        qp.q_w = t_comp'(qw);
        qp.q_x = t_comp'(qx);
        qp.q_y = t_comp'(qy);
        qp.q_z = t_comp'(qz);
        qp.p_w = t_comp'(pw);
        qp.p_x = t_comp'(px);
        qp.p_y = t_comp'(py);
        qp.p_z = t_comp'(pz);
        pair_q.push_back(qp);
    endtask

    task automatic check_field(string name, t_mag want, t_mag got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // sender
    int  send_gap = 0;
    int  send_phase = 0;
    bit  send_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (send_phase == 0) begin
                send_phase = $urandom_range(64, 256);
                send_calm = ($urandom_range(0, 2) == 0);
            end else begin
                send_phase--;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sorted_q.push_back(predict_disorientation(pair_q[0]));
                void'(pair_q.pop_front());
            end
            // hold the offered transaction until it is taken
            if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pair_q.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= pair_q[0];
                    send_gap = pick_gap(send_calm);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    int  recv_gap = 0;
    int  recv_phase = 0;
    bit  recv_calm = 0;
    int  hold_left = 0;

    always @(posedge i_clk) begin
        mag_set_t got;
        mag_set_t want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (recv_phase == 0) begin
                recv_phase = $urandom_range(64, 256);
                recv_calm = ($urandom_range(0, 2) == 0);
            end else begin
                recv_phase--;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                n_results++;
                if (sorted_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none actual %h",
                             $time, got);
                end else begin
                    want = sorted_q.pop_front();
                    check_field("out_largest", want.largest, got.largest);
                    check_field("out_second", want.second, got.second);
                    check_field("out_third", want.third, got.third);
                    check_field("out_smallest", want.smallest, got.smallest);
                end
                // long stall so the pipe fills and backs up the input
                if (n_results == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                recv_gap = pick_gap(recv_calm);
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(Q_ONE, 0, 0, 0, Q_ONE, 0, 0, 0);
        add_pair(Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0);
        add_pair(Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0);
        add_pair(0, 0, 0, Q_ONE, Q_ONE, 0, 0, 0);
        add_pair(Q_ONE, 0, 0, 0, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2);
        add_pair(Q_ONE, 0, 0, 0, Q_ONE / 2, -Q_ONE / 2, Q_ONE / 2, -Q_ONE / 2);
        add_pair(Q_ONE, 0, 0, 0, 759250125, 759250125, 0, 0);
        add_pair(Q_ONE, 0, 0, 0, 759250125, 0, 0, 759250125);
        add_pair(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_pair(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        add_pair(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        add_pair(Q_MIN, 0, 0, 0, Q_MIN, 0, 0, 0);
        add_pair(Q_MAX, 0, 0, 0, Q_MIN, 0, 0, 0);
        add_pair(1, -1, 1, -1, -1, 1, -1, 1);
        add_pair(32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
                 32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555);
        add_pair(-1431655766, -1431655766, -1431655766, -1431655766,
                 1431655765, 1431655765, 1431655765, 1431655765);
        add_pair(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE);
        add_pair(0, Q_ONE, 0, 0, 0, 0, Q_ONE, 0);
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            add_pair(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pair_q.size() != 0 || sorted_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * STAGES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cdq_pkg.sv
rtl/cubic_disorientation_quaternion_top.sv
bench/cubic_disorientation_quaternion_top_tb.sv
